// ===== sv/quad_x_motor_mixer_assert.svh =====
// Assertion macros used by the mixer back end.
`ifndef QUAD_X_MOTOR_MIXER_ASSERT_SVH
`define QUAD_X_MOTOR_MIXER_ASSERT_SVH
`ifndef SYNTHESIS
`define QXM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mixer assertion failed");
`define QXM_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("mixer forbidden condition seen");
`else
`define QXM_ASSERT(lbl, prop)
`define QXM_ASSERT_NEVER(lbl, cond)
`endif
`endif

// ===== sv/qxm_pkg.sv =====
// Types and constants of the quad-X motor mixer.
package qxm_pkg;

    localparam int FRAC_BITS = 8;
    localparam int MOTORS    = 4;
    localparam int LEVEL_W   = 16;
    localparam int CMD_W     = 24;
    localparam int SCALED_W  = LEVEL_W + FRAC_BITS;
    localparam int MIX_W     = ((SCALED_W > CMD_W) ? SCALED_W : CMD_W) + 3;
    localparam int D_W       = MIX_W - 1;
    localparam int QUO_W     = D_W;
    localparam int NUM_W     = SCALED_W;
    localparam int PROD_W    = D_W + NUM_W;
    localparam int RES_W     = D_W + 2;

    localparam int MID_Q_DEPTH = 4;
    localparam int MID_PTR_W   = $clog2(MID_Q_DEPTH);
    localparam int MID_CNT_W   = $clog2(MID_Q_DEPTH + 1);
    localparam int OUT_Q_DEPTH = 2;
    localparam int OUT_PTR_W   = $clog2(OUT_Q_DEPTH);
    localparam int OUT_CNT_W   = $clog2(OUT_Q_DEPTH + 1);

    localparam int ADDR_W = 3;
    localparam logic [ADDR_W-1:0] ADDR_IDLE = 3'd0;
    localparam logic [ADDR_W-1:0] ADDR_CEIL = 3'd4;

    localparam logic [LEVEL_W-1:0] IDLE_RESET = 16'd0;
    localparam logic [LEVEL_W-1:0] CEIL_RESET = 16'd4095;
    localparam logic [LEVEL_W-1:0] DRIVE_MAX  = 16'hFFFF;

    typedef struct packed {
        logic        [LEVEL_W-1:0] thrust;
        logic signed [CMD_W-1:0]   roll_cmd;
        logic signed [CMD_W-1:0]   pitch_cmd;
        logic signed [CMD_W-1:0]   yaw_cmd;
    } cmd_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] front_left_drive;
        logic [LEVEL_W-1:0] front_right_drive;
        logic [LEVEL_W-1:0] back_left_drive;
        logic [LEVEL_W-1:0] back_right_drive;
    } drive_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] idle_level;
        logic [LEVEL_W-1:0] ceiling_level;
    } cfg_t;

    typedef struct packed {
        logic [MOTORS-1:0][D_W-1:0] d;
        logic [D_W-1:0]             den;
        logic                       scale;
        logic                       zero;
    } mid_item_t;

endpackage

// ===== sv/qxm_front.sv =====
// Front end: mixing, min/max search and idle lift of each command beat.
module qxm_front (
    input  logic              clk,
    input  logic              rst_n,
    input  qxm_pkg::cfg_t     cfg,
    input  logic              push,
    output logic              full,
    input  qxm_pkg::cmd_t     command,
    output logic              mid_push,
    output qxm_pkg::mid_item_t mid_item,
    input  logic              mid_full
);
    import qxm_pkg::*;

    logic adv;
    logic v1_reg, v2_reg, v3_reg;
    logic signed [MIX_W-1:0] mix1_reg [MOTORS];
    logic signed [MIX_W-1:0] mix1_next [MOTORS];
    logic signed [MIX_W-1:0] mix2_reg [MOTORS];
    logic signed [MIX_W-1:0] mx2_reg, mn2_reg, mx2_next, mn2_next;
    mid_item_t mid3_reg, mid3_next;

    logic signed [MIX_W-1:0] t_s, r_s, p_s, y_s;
    logic signed [MIX_W-1:0] mxa, mxb, mna, mnb;
    logic signed [MIX_W-1:0] idle_s, ceil_s, base;
    logic signed [MIX_W:0]   diff, den_full, num_s;

    assign adv      = !mid_full;
    assign full     = mid_full;
    assign mid_push = v3_reg && adv;
    assign mid_item = mid3_reg;

    always_comb
    begin
        t_s = signed'(MIX_W'(command.thrust) << FRAC_BITS);
        r_s = MIX_W'(command.roll_cmd);
        p_s = MIX_W'(command.pitch_cmd);
        y_s = MIX_W'(command.yaw_cmd);
        mix1_next[0] = t_s + r_s + p_s + y_s;
        mix1_next[1] = t_s - r_s + p_s - y_s;
        mix1_next[2] = t_s + r_s - p_s - y_s;
        mix1_next[3] = t_s - r_s - p_s + y_s;
    end

    always_comb
    begin
        mxa = (mix1_reg[1] > mix1_reg[0]) ? mix1_reg[1] : mix1_reg[0];
        mxb = (mix1_reg[3] > mix1_reg[2]) ? mix1_reg[3] : mix1_reg[2];
        mna = (mix1_reg[1] < mix1_reg[0]) ? mix1_reg[1] : mix1_reg[0];
        mnb = (mix1_reg[3] < mix1_reg[2]) ? mix1_reg[3] : mix1_reg[2];
        mx2_next = (mxb > mxa) ? mxb : mxa;
        mn2_next = (mnb < mna) ? mnb : mna;
    end

    // A min below idle lifts every drive by idle - min, so offsets are taken from the
    // lower of the two and scaling is then judged on the lifted maximum.
    always_comb
    begin
        idle_s   = signed'(MIX_W'(cfg.idle_level) << FRAC_BITS);
        ceil_s   = signed'(MIX_W'(cfg.ceiling_level) << FRAC_BITS);
        base     = (mn2_reg < idle_s) ? mn2_reg : idle_s;
        mid3_next = '0;
        for (int i = 0; i < MOTORS; i++)
        begin
            diff = (MIX_W+1)'(mix2_reg[i]) - (MIX_W+1)'(base);
            mid3_next.d[i] = D_W'(diff);
        end
        den_full = (MIX_W+1)'(mx2_reg) - (MIX_W+1)'(base);
        num_s    = (MIX_W+1)'(ceil_s) - (MIX_W+1)'(idle_s);
        mid3_next.den   = D_W'(den_full);
        mid3_next.scale = den_full > num_s;
        mid3_next.zero  = den_full == '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= push;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mix1_reg <= mix1_next;
            mix2_reg <= mix1_reg;
            mx2_reg  <= mx2_next;
            mn2_reg  <= mn2_next;
            mid3_reg <= mid3_next;
        end
    end

endmodule

// ===== sv/qxm_queue.sv =====
// Short queue between the front end and the scaling back end.
module qxm_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  qxm_pkg::mid_item_t push_item,
    output logic               full,
    input  logic               pop,
    output qxm_pkg::mid_item_t head,
    output logic               empty
);
    import qxm_pkg::*;

    mid_item_t store_reg [MID_Q_DEPTH];
    logic [MID_PTR_W-1:0] wr_reg, rd_reg;
    logic [MID_CNT_W-1:0] cnt_reg, cnt_next;
    logic do_push, do_pop;

    assign full    = cnt_reg == MID_CNT_W'(MID_Q_DEPTH);
    assign empty   = cnt_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = store_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
                wr_reg <= wr_reg + 1'b1;
            if (do_pop)
                rd_reg <= rd_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            store_reg[wr_reg] <= push_item;
    end

endmodule

// ===== sv/qxm_back.sv =====
// Back end: scale multiply, pipelined divider, clamping and result queue.
`include "quad_x_motor_mixer_assert.svh"
module qxm_back (
    input  logic               clk,
    input  logic               rst_n,
    input  qxm_pkg::cfg_t      cfg,
    input  qxm_pkg::mid_item_t head,
    input  logic               mid_empty,
    output logic               mid_pop,
    output qxm_pkg::drive_t    drive,
    output logic               empty,
    input  logic               pop
);
    import qxm_pkg::*;

    logic en;
    logic [QUO_W:0] vld_reg;
    logic [D_W-1:0] rem_reg [QUO_W+1][MOTORS];
    logic [QUO_W-1:0] lo_reg [QUO_W+1][MOTORS];
    logic [D_W-1:0] den_reg [QUO_W+1];
    logic           neg_reg [QUO_W+1];

    logic [D_W-1:0]   rem0 [MOTORS];
    logic [QUO_W-1:0] lo0 [MOTORS];
    logic [D_W-1:0]   den0;
    logic             neg0;
    logic [D_W-1:0]   step_rem [QUO_W][MOTORS];
    logic [QUO_W-1:0] step_lo [QUO_W][MOTORS];

    logic signed [SCALED_W:0] num_s;
    logic [NUM_W-1:0]  num_abs, mop;
    logic [PROD_W-1:0] prod;
    logic [D_W:0]      cand;
    logic              ge;

    logic signed [RES_W-1:0] idle_r, sq, sum;
    logic [RES_W-FRAC_BITS-1:0] cnt_int;
    logic [LEVEL_W-1:0] lane [MOTORS];
    drive_t result;

    drive_t oq_reg [OUT_Q_DEPTH];
    logic [OUT_PTR_W-1:0] oq_wr_reg, oq_rd_reg;
    logic [OUT_CNT_W-1:0] oq_cnt_reg, oq_cnt_next;
    logic oq_push, oq_pop;

    assign en      = oq_cnt_reg != OUT_CNT_W'(OUT_Q_DEPTH);
    assign mid_pop = en && !mid_empty;

    // Unscaled drives pass through as d / 1, and a zero span gives 0 / 1,
    // so every lane goes through the same divider.
    always_comb
    begin
        num_s   = (SCALED_W+1)'(signed'((SCALED_W+1)'(cfg.ceiling_level) << FRAC_BITS))
                - (SCALED_W+1)'(signed'((SCALED_W+1)'(cfg.idle_level) << FRAC_BITS));
        num_abs = num_s[SCALED_W] ? NUM_W'(-num_s) : NUM_W'(num_s);
        if (head.scale && !head.zero)
        begin
            mop  = num_abs;
            den0 = head.den;
        end
        else
        begin
            mop  = head.scale ? '0 : NUM_W'(1);
            den0 = D_W'(1);
        end
        neg0 = head.scale && !head.zero && num_s[SCALED_W];
        for (int i = 0; i < MOTORS; i++)
        begin
            prod    = PROD_W'(head.d[i]) * PROD_W'(mop);
            rem0[i] = D_W'(prod >> QUO_W);
            lo0[i]  = prod[QUO_W-1:0];
        end
    end

    // One restoring quotient bit per stage.
    always_comb
    begin
        for (int k = 0; k < QUO_W; k++)
        begin
            for (int i = 0; i < MOTORS; i++)
            begin
                cand = {rem_reg[k][i], lo_reg[k][i][QUO_W-1]};
                ge   = cand >= {1'b0, den_reg[k]};
                step_rem[k][i] = ge ? D_W'(cand - {1'b0, den_reg[k]}) : D_W'(cand);
                step_lo[k][i]  = {lo_reg[k][i][QUO_W-2:0], ge};
            end
        end
    end

    always_comb
    begin
        idle_r = signed'(RES_W'(cfg.idle_level) << FRAC_BITS);
        for (int i = 0; i < MOTORS; i++)
        begin
            sq  = neg_reg[QUO_W] ? -signed'(RES_W'(lo_reg[QUO_W][i]))
                                 : signed'(RES_W'(lo_reg[QUO_W][i]));
            sum = idle_r + sq;
            cnt_int = sum[RES_W-1:FRAC_BITS];
            if (sum < 0)
                lane[i] = '0;
            else if (cnt_int > (RES_W-FRAC_BITS)'(DRIVE_MAX))
                lane[i] = DRIVE_MAX;
            else
                lane[i] = LEVEL_W'(cnt_int);
        end
        result.front_left_drive  = lane[0];
        result.front_right_drive = lane[1];
        result.back_left_drive   = lane[2];
        result.back_right_drive  = lane[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[QUO_W-1:0], !mid_empty};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= rem0;
            lo_reg[0]  <= lo0;
            den_reg[0] <= den0;
            neg_reg[0] <= neg0;
            for (int k = 0; k < QUO_W; k++)
            begin
                rem_reg[k+1] <= step_rem[k];
                lo_reg[k+1]  <= step_lo[k];
                den_reg[k+1] <= den_reg[k];
                neg_reg[k+1] <= neg_reg[k];
            end
        end
    end

    assign oq_push = en && vld_reg[QUO_W];
    assign oq_pop  = pop && (oq_cnt_reg != '0);
    assign empty   = oq_cnt_reg == '0;
    assign drive   = oq_reg[oq_rd_reg];

    always_comb
    begin
        oq_cnt_next = oq_cnt_reg;
        if (oq_push && !oq_pop)
            oq_cnt_next = oq_cnt_reg + 1'b1;
        else if (oq_pop && !oq_push)
            oq_cnt_next = oq_cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg  <= '0;
            oq_rd_reg  <= '0;
            oq_cnt_reg <= '0;
        end
        else
        begin
            oq_cnt_reg <= oq_cnt_next;
            if (oq_push)
                oq_wr_reg <= oq_wr_reg + 1'b1;
            if (oq_pop)
                oq_rd_reg <= oq_rd_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_push)
            oq_reg[oq_wr_reg] <= result;
    end

    `QXM_ASSERT(a_oq_bound, oq_cnt_reg <= OUT_CNT_W'(OUT_Q_DEPTH))
    `QXM_ASSERT(a_stall_holds_pipe, !en |=> $stable(vld_reg))
    `QXM_ASSERT_NEVER(a_rem_below_den, vld_reg[QUO_W] && (rem_reg[QUO_W][0] >= den_reg[QUO_W]))

endmodule

// ===== sv/quad_x_motor_mixer.sv =====
// Top level of the quad-X motor mixer with idle lift and ceiling scaling.
//
// Commands enter through a queue-like port: a beat is taken at a rising edge
// with push high and full low. Results leave the same way: while empty is low
// the oldest drive set sits on drive, and pop high at an edge takes that beat.
// The idle and ceiling levels are written over the APB-style port at byte
// addresses 0 and 4; pready is tied high, and reads return the stored level.
// One beat can be taken every cycle while full is low. A command passes
// through three front-end stages (mix, min/max, lift), one queue slot, the
// scale multiply and a 26-stage divider giving one quotient bit per stage,
// then the result queue.
// When the receiver stops popping, the two-entry result queue fills, the
// divider pipeline holds, the four-entry middle queue fills and full rises;
// nothing is dropped. Reset clears all queues and pipeline valid flags and
// sets the idle level to 0 and the ceiling to 4095.
module quad_x_motor_mixer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [qxm_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          push,
    output logic                          full,
    input  qxm_pkg::cmd_t                 command,
    output logic                          empty,
    input  logic                          pop,
    output qxm_pkg::drive_t               drive
);
    import qxm_pkg::*;

    cfg_t      cfg_reg;
    logic      cfg_wr;
    logic      mid_push, mid_full, mid_pop, mid_empty;
    mid_item_t mid_item, mid_head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // Writes to any address other than the two level registers are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.idle_level    <= IDLE_RESET;
            cfg_reg.ceiling_level <= CEIL_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr == ADDR_IDLE)
                cfg_reg.idle_level <= pwdata[LEVEL_W-1:0];
            else if (paddr == ADDR_CEIL)
                cfg_reg.ceiling_level <= pwdata[LEVEL_W-1:0];
        end
    end

    always_comb
    begin
        unique case (paddr)
            ADDR_IDLE: prdata = 32'(cfg_reg.idle_level);
            ADDR_CEIL: prdata = 32'(cfg_reg.ceiling_level);
            default:   prdata = '0;
        endcase
    end

    // The front end mixes and lifts, then hands each beat to the middle
    // queue; it stalls as a whole only while that queue is full.
    qxm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .push     (push),
        .full     (full),
        .command  (command),
        .mid_push (mid_push),
        .mid_item (mid_item),
        .mid_full (mid_full)
    );

    qxm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (mid_push),
        .push_item (mid_item),
        .full      (mid_full),
        .pop       (mid_pop),
        .head      (mid_head),
        .empty     (mid_empty)
    );

    // The back end scales and clamps; it stalls only while its own result
    // queue is full.
    qxm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .head      (mid_head),
        .mid_empty (mid_empty),
        .mid_pop   (mid_pop),
        .drive     (drive),
        .empty     (empty),
        .pop       (pop)
    );

endmodule
